// ===== sv/crpe_pkg.sv =====
// crpe_pkg: payload types, format constants and the level factor table
// for the calorie rate power estimator. No dependencies.
`default_nettype none

package crpe_pkg;

   localparam int CalBits  = 46;
   localparam int NumBits  = 60;   // |dE| times 42 * level factor
   localparam int DenBits  = 30;   // 10000 * dT
   localparam int QuoBits  = 31;   // estimate in 1/256 W, saturating
   localparam int FacBits  = 14;

   localparam logic [6:0]         RecordLength   = 7'd17;
   localparam logic [7:0]         HeaderFirst    = 8'h11;
   localparam logic [7:0]         HeaderSecond   = 8'h20;
   localparam logic [7:0]         PrevCrankReset = 8'hFF;
   localparam logic [9:0]         ThresholdReset = 10'd100;
   localparam logic [FacBits-1:0] DtScale        = 14'd10000;
   localparam logic [15:0]        WattsMax       = 16'hFFFF;

   typedef struct packed {
      logic [6:0]         record_length;
      logic [7:0]         header_first;
      logic [7:0]         header_second;
      logic [7:0]         crank_byte;
      logic [15:0]        time_ticks;
      logic [CalBits-1:0] calories_count;
      logic [7:0]         resistance_level;
   } crpe_req_type;

   typedef struct packed {
      logic        format_ok;
      logic        power_valid;
      logic [15:0] power_watts;
      logic        cadence_event;
   } crpe_rsp_type;

   typedef struct packed {
      logic               start;
      logic [NumBits-1:0] dividend;
      logic [DenBits-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [QuoBits-1:0] quotient;
   } div_rsp_type;

   // 42 times the level factor in hundredths
   function automatic logic [FacBits-1:0] crpe_factor(input logic [4:0] idx);
      logic [FacBits-1:0] f;
      case (idx) inside
         [5'd0:5'd12]: f = 14'd2520;
         5'd13:        f = 14'd3150;
         5'd14:        f = 14'd3822;
         5'd15:        f = 14'd4494;
         5'd16:        f = 14'd5166;
         5'd17:        f = 14'd5838;
         5'd18:        f = 14'd6510;
         5'd19:        f = 14'd7224;
         5'd20:        f = 14'd7896;
         5'd21:        f = 14'd8568;
         5'd22:        f = 14'd9240;
         5'd23:        f = 14'd9912;
         default:      f = 14'd10584;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

// ===== sv/crpe_divider.sv =====
// crpe_divider: restoring divider, one quotient bit per cycle, computing
// min(floor(dividend * 256 / divisor), 2^31 - 1). Depends on crpe_pkg.
`default_nettype none

module crpe_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  crpe_pkg::div_req_type div_req,
   output crpe_pkg::div_rsp_type div_rsp
);
   import crpe_pkg::*;

   localparam int HiBits = NumBits - QuoBits + 8;   // dividend bits above the quotient window
   localparam logic [4:0] LastStep = 5'(QuoBits - 1);

   typedef enum logic [3:0] {
      D_IDLE  = 4'b0001,
      D_CHECK = 4'b0010,
      D_RUN   = 4'b0100,
      D_DONE  = 4'b1000
   } div_state_type;

   div_state_type        state_ff, state_in;
   logic [HiBits-1:0]    hi_ff, hi_in;
   logic [QuoBits-1:0]   low_ff, low_in;
   logic [DenBits-1:0]   den_ff, den_in;
   logic [DenBits-1:0]   rem_ff, rem_in;
   logic [QuoBits-1:0]   quo_ff, quo_in;
   logic [4:0]           cnt_ff, cnt_in;

   logic [DenBits:0]     trial;
   logic [DenBits:0]     trial_sub;
   logic                 trial_ge;
   logic                 overflow;

   assign trial     = {rem_ff, low_ff[QuoBits-1]};
   assign trial_ge  = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};
   assign overflow  = hi_ff >= {{(HiBits-DenBits){1'b0}}, den_ff};

   always_comb begin
      state_in = state_ff;
      hi_in    = hi_ff;
      low_in   = low_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (div_req.start) begin
               hi_in    = div_req.dividend[NumBits-1:QuoBits-8];
               low_in   = {div_req.dividend[QuoBits-9:0], 8'd0};
               den_in   = div_req.divisor;
               state_in = D_CHECK;
            end
         end
         D_CHECK: begin
            if (overflow) begin
               quo_in   = '1;
               state_in = D_DONE;
            end else begin
               // hi < divisor, so it fits the remainder width
               rem_in   = hi_ff[DenBits-1:0];
               quo_in   = '0;
               cnt_in   = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            rem_in = trial_ge ? trial_sub[DenBits-1:0] : trial[DenBits-1:0];
            quo_in = {quo_ff[QuoBits-2:0], trial_ge};
            low_in = {low_ff[QuoBits-2:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == LastStep) begin
               state_in = D_DONE;
            end
         end
         D_DONE: begin
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      hi_ff  <= hi_in;
      low_ff <= low_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done     = (state_ff == D_DONE);
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== sv/calorie_rate_power_estimator.sv =====
// calorie_rate_power_estimator: record check, cadence flag, energy-rate power
// estimate and smoothing. Depends on crpe_pkg and crpe_divider.
//
//   port group   dir   handshake            beat
//   req_*        in    req_valid/req_stall  crpe_req_type sensor record
//   rsp_*        out   rsp_valid/rsp_stall  crpe_rsp_type result
//   csr_*        in    csr_wr_en            jump threshold, 10 bits
//
// A record with a power estimate runs the check, magnitude, multiply, divide,
// difference, halving and select states; the divide waits on the 31-step
// serial divider, whose steps a saturating estimate skips. A bad record, or one
// with no estimate, goes from check to output. One record is in work at a time.
// Reset is synchronous; it restores the threshold and all tracking state.
// A stalled result holds in the output register; a new record is accepted
// meanwhile, and its result waits until the output register frees.
`default_nettype none

module calorie_rate_power_estimator #(
   parameter int LEVEL_COUNT = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  crpe_pkg::crpe_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output crpe_pkg::crpe_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic [9:0]             csr_wr_data
);
   import crpe_pkg::*;

   localparam logic [7:0] LastIdx = 8'(LEVEL_COUNT - 1);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_CHECK = 11'b00000000010,
      ST_ABS   = 11'b00000000100,
      ST_MULN  = 11'b00000001000,
      ST_MULD  = 11'b00000010000,
      ST_DIVGO = 11'b00000100000,
      ST_DIVW  = 11'b00001000000,
      ST_DIFF  = 11'b00010000000,
      ST_HALF  = 11'b00100000000,
      ST_SEL   = 11'b01000000000,
      ST_OUT   = 11'b10000000000
   } st_type;

   st_type             state_ff, state_in;
   crpe_req_type       req_ff;
   logic [9:0]         thr_ff;
   logic [CalBits-1:0] prev_cal_ff;
   logic [15:0]        prev_time_ff;
   logic [7:0]         prev_crank_ff;
   logic [31:0]        sm_ff;
   logic               seen_ff;

   logic [CalBits:0]   de_ff;
   logic [15:0]        dt_ff;
   logic               sign_ff;
   logic [CalBits-1:0] mag_ff;
   logic [NumBits-1:0] num_ff;
   logic [DenBits-1:0] den_ff;
   logic [31:0]        p_ff;
   logic [32:0]        diff_ff;
   logic [32:0]        half_ff;
   logic               near_ff;
   logic               res_ok_ff, res_pv_ff, res_cad_ff;

   logic               rsp_valid_ff;
   crpe_rsp_type       rsp_data_ff;

   logic               accept;
   logic               out_free;
   logic               fmt_ok;
   logic [7:0]         idx_raw;
   logic [4:0]         idx;
   logic [31:0]        q_ext;
   logic [32:0]        half_sum;
   logic [32:0]        thr_pos;
   logic [32:0]        thr_neg;
   logic [32:0]        sm_half;
   logic [32:0]        new_val;
   logic [32:0]        rnd;
   logic [15:0]        watts;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   crpe_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign fmt_ok = (req_ff.record_length == RecordLength) &&
                   (req_ff.header_first == HeaderFirst) &&
                   (req_ff.header_second == HeaderSecond);

   // level 0 acts as level 1, above the table end acts as the last level
   always_comb begin
      idx_raw = (req_ff.resistance_level == 8'd0) ? 8'd0 : req_ff.resistance_level - 8'd1;
      if (idx_raw > LastIdx) begin
         idx_raw = LastIdx;
      end
      idx = idx_raw[4:0];
   end

   assign div_req.start    = (state_ff == ST_DIVGO);
   assign div_req.dividend = num_ff;
   assign div_req.divisor  = den_ff;

   assign q_ext    = {1'b0, div_rsp.quotient};
   assign half_sum = diff_ff + {32'd0, diff_ff[32]};   // truncate toward zero
   assign thr_pos  = {15'd0, thr_ff, 8'd0};
   assign thr_neg  = 33'd0 - thr_pos;
   assign sm_half  = {sm_ff[31], sm_ff} + half_ff;
   assign new_val  = (!seen_ff || near_ff) ? {p_ff[31], p_ff} : sm_half;
   assign rnd      = {1'b0, sm_ff} + 33'd128;
   assign watts    = (rnd[32:24] != 9'd0) ? WattsMax : rnd[23:8];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_CHECK;
         ST_CHECK: begin
            if (!fmt_ok || prev_cal_ff == '0 || req_ff.time_ticks == prev_time_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_ABS;
            end
         end
         ST_ABS:   state_in = ST_MULN;
         ST_MULN:  state_in = ST_MULD;
         ST_MULD:  state_in = ST_DIVGO;
         ST_DIVGO: state_in = ST_DIVW;
         ST_DIVW:  if (div_rsp.done) state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_HALF;
         ST_HALF:  state_in = ST_SEL;
         ST_SEL:   state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         thr_ff        <= ThresholdReset;
         prev_cal_ff   <= '0;
         prev_time_ff  <= '0;
         prev_crank_ff <= PrevCrankReset;
         sm_ff         <= '0;
         seen_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (state_ff == ST_CHECK && fmt_ok) begin
            if (req_ff.crank_byte != prev_crank_ff) begin
               prev_crank_ff <= req_ff.crank_byte;
            end
            prev_cal_ff  <= req_ff.calories_count;
            prev_time_ff <= req_ff.time_ticks;
         end
         if (state_ff == ST_SEL) begin
            sm_ff   <= new_val[32] ? 32'd256 : new_val[31:0];
            seen_ff <= 1'b1;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath and payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_CHECK) begin
         res_ok_ff  <= fmt_ok;
         res_pv_ff  <= 1'b0;
         res_cad_ff <= fmt_ok && (req_ff.crank_byte != prev_crank_ff);
         de_ff      <= {1'b0, req_ff.calories_count} - {1'b0, prev_cal_ff};
         dt_ff      <= req_ff.time_ticks - prev_time_ff;
      end
      if (state_ff == ST_ABS) begin
         sign_ff <= de_ff[CalBits];
         mag_ff  <= de_ff[CalBits] ? CalBits'(~de_ff + 1'b1) : de_ff[CalBits-1:0];
      end
      if (state_ff == ST_MULN) begin
         num_ff <= mag_ff * crpe_factor(idx);
      end
      if (state_ff == ST_MULD) begin
         den_ff <= dt_ff * DtScale;
      end
      if (state_ff == ST_DIVW && div_rsp.done) begin
         p_ff <= sign_ff ? 32'd0 - q_ext : q_ext;
      end
      if (state_ff == ST_DIFF) begin
         diff_ff <= {p_ff[31], p_ff} - {sm_ff[31], sm_ff};
      end
      if (state_ff == ST_HALF) begin
         half_ff <= {half_sum[32], half_sum[32:1]};
         near_ff <= ($signed(diff_ff) < $signed(thr_pos)) &&
                    ($signed(diff_ff) > $signed(thr_neg));
      end
      if (state_ff == ST_SEL) begin
         res_pv_ff <= 1'b1;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff.format_ok     <= res_ok_ff;
         rsp_data_ff.power_valid   <= res_pv_ff;
         rsp_data_ff.power_watts   <= res_pv_ff ? watts : 16'd0;
         rsp_data_ff.cadence_event <= res_cad_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pv_needs_fmt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.power_valid |-> rsp_data.format_ok)
      else $error("power beat without a valid record format");

   a_cad_needs_fmt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cadence_event |-> rsp_data.format_ok)
      else $error("cadence flag on a bad-format record");

   a_watts_needs_pv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.power_watts != 16'd0) |-> rsp_data.power_valid)
      else $error("nonzero watts without a power estimate");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIVW)
      else $error("divider finished while the sequencer was not waiting");

endmodule

`default_nettype wire

// ===== tb/calorie_rate_power_estimator_tb.sv =====
// calorie_rate_power_estimator_tb: self-checking bench for the power estimator.
// Directed records, then random ride sequences under several jump thresholds,
// each result checked against a fixed expectation or a local predictor. Depends on crpe_pkg and the RTL.
`default_nettype none

module calorie_rate_power_estimator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import crpe_pkg::*;

   localparam int          LevelCount = 25;
   localparam longint      EstMax     = 64'h7FFF_FFFF;
   localparam int unsigned CycleLimit = 1_000_000;
   localparam int          SettleGap  = 60;
   localparam int          PhaseLen   = 160;
   localparam crpe_rsp_type Rejected  = '0;

   typedef struct {
      crpe_req_type rec;
      bit           fixed;
      crpe_rsp_type want;
   } plan_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   crpe_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   crpe_rsp_type rsp_data;
   logic         csr_wr_en;
   logic [9:0]   csr_wr_data;

   // predictor state
   logic [9:0]  thr_watts     = ThresholdReset;
   logic [45:0] last_cal      = '0;
   logic [15:0] last_time     = '0;
   int          smooth_q8     = 0;
   bit          have_estimate = 1'b0;
   logic [7:0]  last_crank    = PrevCrankReset;

   // ride sequence state for random records
   logic [45:0] seq_cal   = 46'd3_000_000;
   logic [15:0] seq_time  = '0;
   logic [7:0]  seq_crank = '0;

   crpe_rsp_type results_due[$];
   plan_row_type plan[$];
   bit           calm = 1'b0;
   int unsigned  errors = 0;
   int unsigned  n_sent = 0;
   int unsigned  n_checked = 0;
   int unsigned  n_power = 0;
   int unsigned  n_rejected = 0;
   int unsigned  n_settings = 1;
   int unsigned  cycle_count = 0;

   calorie_rate_power_estimator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // level factor in hundredths, by clamped table slot
   function automatic int level_pct(input int idx);
      case (idx)
         13:      return 75;
         14:      return 91;
         15:      return 107;
         16:      return 123;
         17:      return 139;
         18:      return 155;
         19:      return 172;
         20:      return 188;
         21:      return 204;
         22:      return 220;
         23:      return 236;
         default: return idx < 13 ? 60 : 252;
      endcase
   endfunction

   function automatic crpe_rsp_type estimate_power(input crpe_req_type r);
      crpe_rsp_type o;
      longint de, p, diff, nxt, w;
      longint unsigned mag, num, den, quo, rem, est, adiff;
      logic [15:0] dt;
      int idx;
      o = '0;
      if (r.record_length != RecordLength || r.header_first != HeaderFirst ||
          r.header_second != HeaderSecond)
         return o;
      o.format_ok = 1'b1;
      if (r.crank_byte != last_crank) begin
         o.cadence_event = 1'b1;
         last_crank = r.crank_byte;
      end
      if (last_cal == '0 || r.time_ticks == last_time) begin
         last_cal  = r.calories_count;
         last_time = r.time_ticks;
         return o;
      end
      de  = longint'({18'd0, r.calories_count}) - longint'({18'd0, last_cal});
      dt  = r.time_ticks - last_time;
      idx = (r.resistance_level == 8'd0) ? 0 : int'(r.resistance_level) - 1;
      if (idx > LevelCount - 1)
         idx = LevelCount - 1;
      mag = (de < 0) ? -de : de;
      num = mag * (42 * level_pct(idx));
      den = 64'(dt) * 10000;
      quo = num / den;
      rem = num % den;
      est = (quo >= (64'd1 << 23)) ? EstMax : quo * 256 + (rem * 256) / den;
      if (est > EstMax)
         est = EstMax;
      p = (de < 0) ? -longint'(est) : longint'(est);
      last_cal  = r.calories_count;
      last_time = r.time_ticks;
      // jumps at or past the threshold only move half way
      diff  = p - longint'(smooth_q8);
      adiff = (diff < 0) ? -diff : diff;
      if (!have_estimate || adiff < longint'(thr_watts) * 256)
         nxt = p;
      else
         nxt = longint'(smooth_q8) + diff / 2;
      if (nxt < 0)
         nxt = 256;
      smooth_q8     = int'(nxt);
      have_estimate = 1'b1;
      w = (nxt + 128) >>> 8;
      if (w > 65535)
         w = 65535;
      o.power_valid = 1'b1;
      o.power_watts = w[15:0];
      return o;
   endfunction

   // 55% none, then short, medium and a few long gaps
   function automatic int idle_len();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 55)
         return 0;
      if (sel < 85)
         return $urandom_range(1, 3);
      if (sel < 97)
         return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   // mostly plausible ride records, some noise and near-miss headers
   function automatic crpe_req_type next_ride_record();
      crpe_req_type r;
      int unsigned kind, pick;
      logic [63:0] wide;
      logic [15:0] dt;
      wide = {$urandom(), $urandom()};
      kind = $urandom_range(0, 99);
      r.record_length    = RecordLength;
      r.header_first     = HeaderFirst;
      r.header_second    = HeaderSecond;
      r.crank_byte       = ($urandom_range(0, 99) < 40) ? seq_crank : 8'($urandom_range(0, 255));
      r.resistance_level = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 25))
                                                        : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 80)
         dt = 16'($urandom_range(256, 4096));
      else if (pick < 86)
         dt = '0;
      else if (pick < 93)
         dt = 16'($urandom_range(1, 16));
      else
         dt = 16'($urandom_range(0, 65535));
      r.time_ticks = seq_time + dt;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         r.calories_count = seq_cal + 46'($urandom_range(0, 1 << 21));
      else if (pick < 80)
         r.calories_count = seq_cal - 46'($urandom_range(0, 1 << 20));
      else if (pick < 84)
         r.calories_count = '0;
      else if (pick < 90)
         r.calories_count = wide[45:0];
      else
         r.calories_count = seq_cal + 46'(wide[31:0]);
      if (kind < 8) begin
         r.record_length  = 7'($urandom_range(0, 127));
         r.header_first   = 8'($urandom_range(0, 255));
         r.header_second  = 8'($urandom_range(0, 255));
         r.calories_count = wide[45:0];
         r.time_ticks     = 16'($urandom_range(0, 65535));
         return r;
      end
      if (kind < 14) begin
         case ($urandom_range(0, 2))
            0:       r.record_length = 7'($urandom_range(0, 127));
            1:       r.header_first  = 8'($urandom_range(0, 255));
            default: r.header_second = 8'($urandom_range(0, 255));
         endcase
         return r;
      end
      seq_cal   = r.calories_count;
      seq_time  = r.time_ticks;
      seq_crank = r.crank_byte;
      return r;
   endfunction

   task automatic add_row(input logic [6:0] len, input logic [7:0] h1, input logic [7:0] h2,
                          input logic [7:0] crank, input logic [15:0] tim,
                          input logic [45:0] cal, input logic [7:0] lvl,
                          input bit fixed = 1'b0, input crpe_rsp_type want = '0);
      plan_row_type row;
      row.rec   = '{len, h1, h2, crank, tim, cal, lvl};
      row.fixed = fixed;
      row.want  = want;
      plan.push_back(row);
   endtask

   task automatic note_mismatch(input string what);
      errors++;
      $display("MISMATCH at %0t, result %0d: %s", $time, n_checked, what);
   endtask

   // called right after a rising edge; returns at the edge the beat is taken
   task automatic send_record(input crpe_req_type r, input bit fixed, input crpe_rsp_type want);
      crpe_rsp_type guess;
      int gap;
      gap = calm ? 0 : idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      guess = estimate_power(r);
      results_due.push_back(fixed ? want : guess);
      n_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (results_due.size() != 0)
         @(posedge clock);
      repeat (SettleGap) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [9:0] v);
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      thr_watts = v;
      n_settings++;
   endtask

   // result side back-pressure
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         n = calm ? 0 : idle_len();
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      crpe_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            note_mismatch($sformatf("result %p with nothing outstanding", rsp_data));
         end else begin
            want = results_due.pop_front();
            n_checked++;
            if (want.power_valid)
               n_power++;
            if (!want.format_ok)
               n_rejected++;
            if (rsp_data.format_ok !== want.format_ok)
               note_mismatch($sformatf("format_ok %b, expected %b",
                                       rsp_data.format_ok, want.format_ok));
            if (rsp_data.power_valid !== want.power_valid)
               note_mismatch($sformatf("power_valid %b, expected %b",
                                       rsp_data.power_valid, want.power_valid));
            if (rsp_data.power_watts !== want.power_watts)
               note_mismatch($sformatf("power_watts %0d, expected %0d",
                                       rsp_data.power_watts, want.power_watts));
            if (rsp_data.cadence_event !== want.cadence_event)
               note_mismatch($sformatf("cadence_event %b, expected %b",
                                       rsp_data.cadence_event, want.cadence_event));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, results_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      logic [9:0] thr;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;

      // bad format, first records, then estimates across levels and odd deltas
      add_row(7'd0, HeaderFirst, HeaderSecond, 8'h00, 16'h0000, 46'd0, 8'd1, 1'b1, Rejected);
      add_row(7'd127, HeaderFirst, HeaderSecond, 8'hFF, 16'hFFFF, 46'h3FFF_FFFF_FFFF,
              8'hFF, 1'b1, Rejected);
      add_row(RecordLength, 8'hFF, HeaderSecond, 8'h00, 16'h0000, 46'd1000, 8'd1,
              1'b1, Rejected);
      add_row(RecordLength, HeaderFirst, 8'hDF, 8'h00, 16'h0000, 46'd1000, 8'd1,
              1'b1, Rejected);
      // no estimate yet: count is zero, then time unchanged
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'hFF, 16'd0, 46'd0, 8'd1,
              1'b1, crpe_rsp_type'{1'b1, 1'b0, 16'd0, 1'b0});
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h00, 16'd1024, 46'd400000, 8'd1,
              1'b1, crpe_rsp_type'{1'b1, 1'b0, 16'd0, 1'b1});
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h00, 16'd1024, 46'd800000, 8'd1,
              1'b1, crpe_rsp_type'{1'b1, 1'b0, 16'd0, 1'b0});
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h01, 16'd2048, 46'd1200000, 8'd0);
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h01, 16'd3072, 46'd1600000, 8'd13);
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h01, 16'd4096, 46'd2000000, 8'd14);
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h01, 16'd5120, 46'd2400000, 8'd25);
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h01, 16'd6144, 46'd2800000, 8'd26);
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h01, 16'hFFF0, 46'd3200000, 8'd255);
      // time wraps, then falling counts drive the power negative
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h01, 16'h0010, 46'd3250000, 8'd20);
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h01, 16'h0410, 46'd1000, 8'd20);
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h01, 16'h0810, 46'd500, 8'd1);
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h01, 16'h0C10, 46'd0, 8'd1);
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h01, 16'h1010, 46'd5, 8'd1,
              1'b1, crpe_rsp_type'{1'b1, 1'b0, 16'd0, 1'b0});
      // full-scale count over one tick saturates
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h01, 16'h1011, 46'h3FFF_FFFF_FFFF,
              8'd25, 1'b1, crpe_rsp_type'{1'b1, 1'b1, WattsMax, 1'b0});
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h01, 16'h1012, 46'h3FFF_FFFF_FFFF,
              8'd25);
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'hAA, 16'hFFFF, 46'h2AAA_AAAA_AAAA,
              8'h55);
      add_row(RecordLength, HeaderFirst, HeaderSecond, 8'h55, 16'h5555, 46'h1555_5555_5555,
              8'hAA);
      add_row(RecordLength, 8'h10, HeaderSecond, 8'h55, 16'h6000, 46'd7, 8'd3,
              1'b1, Rejected);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_record(plan[i].rec, plan[i].fixed, plan[i].want);

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         case (ph)
            0:       thr = 10'd0;
            1:       thr = 10'd1023;
            2:       thr = 10'd1;
            3:       thr = 10'd512;
            default: thr = 10'($urandom_range(0, 1023));
         endcase
         set_threshold(thr);
         calm = (ph == 2);
         repeat (PhaseLen)
            send_record(next_ride_record(), 1'b0, Rejected);
      end
      calm = 1'b0;
      settle();

      $display("covered %0d records under %0d threshold settings, %0d results checked",
               n_sent, n_settings, n_checked);
      $display("%0d power estimates, %0d rejected records, %0d mismatches",
               n_power, n_rejected, errors);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
sv/crpe_pkg.sv
sv/crpe_divider.sv
sv/calorie_rate_power_estimator.sv
tb/calorie_rate_power_estimator_tb.sv
